// ===== design/set_assoc_write_back_cache_assert.svh =====
// assertion macros for the cache checker
`ifndef SET_ASSOC_WRITE_BACK_CACHE_ASSERT_SVH
`define SET_ASSOC_WRITE_BACK_CACHE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define SAWBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache port check failed");

// next-cycle implication
`define SAWBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache port check failed");

`endif

// ===== design/sawbc_pkg.sv =====
// shared constants and the lfsr step function of the cache
package sawbc_pkg;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;

    localparam logic [1:0] KIND_READ_DATA = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_FILL_REQ  = 2'd2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam int BLOCK_NUM_W = 26;
    localparam int BEAT_W      = 4;

    // one galois step, right shift with feedback taps
    function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
        logic [15:0] nxt;
        nxt = cur >> 1;
        if (cur[0])
        begin
            nxt = nxt ^ LFSR_TAPS;
        end
        return nxt;
    endfunction

endpackage

// ===== design/sawbc_data_ram.sv =====
// line word store, one write port and one registered read port
module sawbc_data_ram
    import sawbc_pkg::*;
#(
    parameter int ADDR_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [31:0]          wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [31:0]          rdata
);

    logic [31:0] mem [(2**ADDR_BITS)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/set_assoc_write_back_cache.sv =====
// top level of the set-associative write-back cache
// transactions enter on start while busy is low and leave as one-cycle strobes
// on the result ports; the receiver cannot stall. a read hit walks through
// accept, tag lookup and data read, and a write hit the same, with no
// result. a miss walks through accept, tag lookup and fill request for a clean
// victim and sends WORDS writeback beats before the fill request for a dirty one,
// one writeback beat per cycle from the word ram's read port.
// each fill beat is taken while the block is idle; after the last one the fill read
// and hit states do the read-modify of the pending word. tag and word stores are
// synchronous rams with registered reads, so every access walks through them in order.
module set_assoc_write_back_cache
    import sawbc_pkg::*;
#(
    parameter int BLOCK_OFFSET_BITS = 6,
    parameter int SIZE_BITS         = 14,
    parameter int WAY_BITS          = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] address,
    input  logic [31:0] data_in,
    input  logic [31:0] write_mask,
    output logic        strobe,
    output logic [1:0]  result_kind,
    output logic [25:0] block_number,
    output logic [3:0]  beat_index,
    output logic [31:0] data_out,
    output logic        last
);

    localparam int LINE_BITS  = SIZE_BITS - BLOCK_OFFSET_BITS;
    localparam int SET_BITS   = LINE_BITS - WAY_BITS;
    localparam int WORD_BITS  = BLOCK_OFFSET_BITS - 2;
    localparam int TAG_BITS   = 32 - BLOCK_OFFSET_BITS - SET_BITS;
    localparam int DADDR_BITS = SIZE_BITS - 2;
    localparam int NUM_LINES  = 2 ** LINE_BITS;
    localparam int NUM_SETS   = 2 ** SET_BITS;
    localparam int NUM_WAYS   = 2 ** WAY_BITS;
    localparam int WORDS      = 2 ** WORD_BITS;
    localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W      = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int WORD_W     = (WORD_BITS > 0) ? WORD_BITS : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WB,
        S_FREQ,
        S_FILL_RD,
        S_HIT
    } state_t;

    state_t                state_reg;
    logic [NUM_LINES-1:0]  valid_reg;
    logic [NUM_LINES-1:0]  dirty_reg;
    logic [15:0]           lfsr_reg;
    logic                  pend_reg;
    logic [WORD_W-1:0]     fill_cnt_reg;
    logic [WORD_W-1:0]     wb_cnt_reg;
    logic                  acc_write_reg;
    logic [31:0]           acc_addr_reg;
    logic [31:0]           acc_data_reg;
    logic [31:0]           acc_mask_reg;
    logic [LINE_BITS-1:0]  acc_line_reg;
    logic [BLOCK_NUM_W-1:0] wb_block_reg;

    logic                  strobe_reg;
    logic [1:0]            kind_reg;
    logic [BLOCK_NUM_W-1:0] block_reg;
    logic [BEAT_W-1:0]     beat_reg;
    logic [31:0]           dout_reg;
    logic                  last_reg;

    // address fields of the held access
    logic [SET_W-1:0]      acc_set;
    logic [TAG_BITS-1:0]   acc_tag;
    logic [WORD_W-1:0]     acc_word;
    logic [SET_W-1:0]      in_set;

    assign acc_set  = acc_addr_reg[BLOCK_OFFSET_BITS +: SET_W] & SET_W'(NUM_SETS - 1);
    assign acc_tag  = TAG_BITS'(acc_addr_reg >> (BLOCK_OFFSET_BITS + SET_BITS));
    assign acc_word = acc_addr_reg[2 +: WORD_W] & WORD_W'(WORDS - 1);
    assign in_set   = address[BLOCK_OFFSET_BITS +: SET_W] & SET_W'(NUM_SETS - 1);

    function automatic logic [DADDR_BITS-1:0] word_addr(input logic [LINE_BITS-1:0] ln,
                                                        input logic [WORD_W-1:0] wd);
        return (DADDR_BITS'(ln) << WORD_BITS) | DADDR_BITS'(wd & WORD_W'(WORDS - 1));
    endfunction

    function automatic logic [LINE_BITS-1:0] line_of(input logic [SET_W-1:0] st,
                                                     input logic [WAY_W-1:0] wy);
        return (LINE_BITS'(st) << WAY_BITS) | LINE_BITS'(wy & WAY_W'(NUM_WAYS - 1));
    endfunction

    // tag store, one ram per way so a whole set is read at once
    logic                  tag_we;
    logic [SET_W-1:0]      tag_wset;
    logic [WAY_W-1:0]      tag_wway;
    logic [TAG_BITS-1:0]   tag_q [NUM_WAYS];

    for (genvar w = 0; w < NUM_WAYS; w++)
    begin : g_tag
        logic [TAG_BITS-1:0] tag_mem [NUM_SETS];

        always_ff @(posedge clk)
        begin
            if (tag_we && (tag_wway == WAY_W'(w)))
            begin
                tag_mem[tag_wset] <= acc_tag;
            end
            tag_q[w] <= tag_mem[in_set];
        end
    end

    // the final fill beat writes the tag of the pending access
    logic fill_take;
    logic fill_last;

    assign fill_take = (state_reg == S_IDLE) && start && (req_type == REQ_FILL) && pend_reg;
    assign fill_last = fill_cnt_reg == WORD_W'(WORDS - 1);
    assign tag_we    = fill_take && fill_last;
    assign tag_wset  = SET_W'(acc_line_reg >> WAY_BITS);
    assign tag_wway  = WAY_W'(acc_line_reg) & WAY_W'(NUM_WAYS - 1);

    // hit search over the ways of the set
    logic             hit;
    logic [WAY_W-1:0] hit_way;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[line_of(acc_set, WAY_W'(w))] && (tag_q[w] == acc_tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // victim choice from the stepped lfsr
    logic [15:0]          lfsr_adv;
    logic [WAY_W-1:0]     vic_way;
    logic [LINE_BITS-1:0] vic_line;
    logic                 vic_dirty;
    logic [31:0]          vic_block;

    assign lfsr_adv  = lfsr_step(lfsr_reg);
    assign vic_way   = WAY_W'(lfsr_adv) & WAY_W'(NUM_WAYS - 1);
    assign vic_line  = line_of(acc_set, vic_way);
    assign vic_dirty = valid_reg[vic_line] && dirty_reg[vic_line];
    assign vic_block = (32'(tag_q[vic_way]) << SET_BITS) | 32'(acc_set);

    // word ram ports
    logic                  ram_we;
    logic [DADDR_BITS-1:0] ram_waddr;
    logic [31:0]           ram_wdata;
    logic [DADDR_BITS-1:0] ram_raddr;
    logic [31:0]           ram_q;
    logic [31:0]           merged;

    assign merged = (ram_q & ~acc_mask_reg) | (acc_data_reg & acc_mask_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = word_addr(acc_line_reg, fill_cnt_reg);
        ram_wdata = data_in;
        if (fill_take)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == S_HIT) && acc_write_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = word_addr(acc_line_reg, acc_word);
            ram_wdata = merged;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_LOOKUP:
            begin
                ram_raddr = hit ? word_addr(line_of(acc_set, hit_way), acc_word)
                                : word_addr(vic_line, '0);
            end
            S_WB:      ram_raddr = word_addr(acc_line_reg, wb_cnt_reg + WORD_W'(1));
            default:   ram_raddr = word_addr(acc_line_reg, acc_word);
        endcase
    end

    sawbc_data_ram #(
        .ADDR_BITS (DADDR_BITS)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // sequencer with registered result ports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            pend_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
            acc_write_reg <= 1'b0;
            acc_addr_reg  <= '0;
            acc_data_reg  <= '0;
            acc_mask_reg  <= '0;
            acc_line_reg  <= '0;
            wb_block_reg  <= '0;
            strobe_reg    <= 1'b0;
            kind_reg      <= KIND_READ_DATA;
            block_reg     <= '0;
            beat_reg      <= '0;
            dout_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    strobe_reg <= 1'b0;
                    if (start)
                    begin
                        if (req_type == REQ_FILL)
                        begin
                            if (pend_reg)
                            begin
                                if (fill_last)
                                begin
                                    fill_cnt_reg            <= '0;
                                    pend_reg                <= 1'b0;
                                    valid_reg[acc_line_reg] <= 1'b1;
                                    dirty_reg[acc_line_reg] <= 1'b0;
                                    state_reg               <= S_FILL_RD;
                                end
                                else
                                begin
                                    fill_cnt_reg <= fill_cnt_reg + WORD_W'(1);
                                end
                            end
                        end
                        else if (((req_type == REQ_READ) || (req_type == REQ_WRITE)) && !pend_reg)
                        begin
                            acc_write_reg <= req_type == REQ_WRITE;
                            acc_addr_reg  <= address;
                            acc_data_reg  <= data_in;
                            acc_mask_reg  <= write_mask;
                            state_reg     <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP:
                begin
                    strobe_reg <= 1'b0;
                    if (hit)
                    begin
                        acc_line_reg <= line_of(acc_set, hit_way);
                        state_reg    <= S_HIT;
                    end
                    else
                    begin
                        lfsr_reg            <= lfsr_adv;
                        acc_line_reg        <= vic_line;
                        wb_block_reg        <= BLOCK_NUM_W'(vic_block);
                        wb_cnt_reg          <= '0;
                        fill_cnt_reg        <= '0;
                        valid_reg[vic_line] <= 1'b0;
                        dirty_reg[vic_line] <= 1'b0;
                        pend_reg            <= 1'b1;
                        if (vic_dirty)
                        begin
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            state_reg <= S_FREQ;
                        end
                    end
                end
                S_WB:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg   <= KIND_WRITEBACK;
                    block_reg  <= wb_block_reg;
                    beat_reg   <= BEAT_W'(wb_cnt_reg);
                    dout_reg   <= ram_q;
                    last_reg   <= 1'b0;
                    wb_cnt_reg <= wb_cnt_reg + WORD_W'(1);
                    if (wb_cnt_reg == WORD_W'(WORDS - 1))
                    begin
                        state_reg <= S_FREQ;
                    end
                end
                S_FREQ:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg   <= KIND_FILL_REQ;
                    block_reg  <= BLOCK_NUM_W'(acc_addr_reg >> BLOCK_OFFSET_BITS);
                    beat_reg   <= '0;
                    dout_reg   <= '0;
                    last_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_FILL_RD:
                begin
                    // word ram read of the pending word is in flight
                    strobe_reg <= 1'b0;
                    state_reg  <= S_HIT;
                end
                S_HIT:
                begin
                    strobe_reg <= !acc_write_reg;
                    if (acc_write_reg)
                    begin
                        dirty_reg[acc_line_reg] <= 1'b1;
                    end
                    else
                    begin
                        kind_reg   <= KIND_READ_DATA;
                        block_reg  <= '0;
                        beat_reg   <= '0;
                        dout_reg   <= ram_q;
                        last_reg   <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    strobe_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign strobe       = strobe_reg;
    assign result_kind  = kind_reg;
    assign block_number = block_reg;
    assign beat_index   = beat_reg;
    assign data_out     = dout_reg;
    assign last         = last_reg;

endmodule

// ===== design/sawbc_checker.sv =====
// port-level checks of the cache, bound to the top level
`include "set_assoc_write_back_cache_assert.svh"

module sawbc_checker
    import sawbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic [31:0] address,
    input logic [31:0] data_in,
    input logic [31:0] write_mask,
    input logic        strobe,
    input logic [1:0]  result_kind,
    input logic [25:0] block_number,
    input logic [3:0]  beat_index,
    input logic [31:0] data_out,
    input logic        last
);

    // a transaction's final result coincides with the block going idle
    `SAWBC_ASSERT_NOW(a_last_idle, strobe && last, !busy)
    // results other than the final one come while the block is still busy
    `SAWBC_ASSERT_NOW(a_more_busy, strobe && !last, busy)
    // writeback beats are never final and are followed by another result
    `SAWBC_ASSERT_NEXT(a_wb_follow, strobe && (result_kind == KIND_WRITEBACK), strobe)
    // read data always closes its transaction
    `SAWBC_ASSERT_NOW(a_read_last, strobe && (result_kind == KIND_READ_DATA), last)

endmodule

bind set_assoc_write_back_cache sawbc_checker u_sawbc_checker (.*);

// ===== verif/set_assoc_write_back_cache_test.sv =====
// self-checking testbench for the set-associative write-back cache
module set_assoc_write_back_cache_test;
    import sawbc_pkg::*;

    // geometry at the default parameters of the block
    localparam int OFFSET_BITS = 6;
    localparam int SET_BITS    = 6;
    localparam int WAY_BITS    = 2;
    localparam int WORDS       = 1 << (OFFSET_BITS - 2);
    localparam int LINES       = 1 << (SET_BITS + WAY_BITS);
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 60;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [25:0] blk;
        logic [3:0]  beat;
        logic [31:0] word;
        logic        fin;
    } cache_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] mask;
        int          phase;
        bit          drain;
        int          n_res;
    } cache_access_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] data_in;
    logic [31:0] write_mask;
    logic        strobe;
    logic [1:0]  result_kind;
    logic [25:0] block_number;
    logic [3:0]  beat_index;
    logic [31:0] data_out;
    logic        last;

    set_assoc_write_back_cache dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .address      (address),
        .data_in      (data_in),
        .write_mask   (write_mask),
        .strobe       (strobe),
        .result_kind  (result_kind),
        .block_number (block_number),
        .beat_index   (beat_index),
        .data_out     (data_out),
        .last         (last)
    );

    // shadow copy of the cache contents
    bit          sh_valid [LINES];
    bit          sh_dirty [LINES];
    logic [19:0] sh_tag   [LINES];
    logic [31:0] sh_words [LINES * WORDS];
    logic [15:0] sh_lfsr;
    bit          miss_open;
    bit          miss_is_write;
    logic [31:0] miss_addr;
    logic [31:0] miss_data;
    logic [31:0] miss_mask;
    int          miss_line;
    int          fill_words;

    cache_access_t access_queue[$];   // transactions waiting to be driven
    cache_result_t planned[$];        // results worked out at generation time
    cache_result_t awaited[$];        // results of accepted transactions
    int            errors;
    int            cycles;
    int            hold_count;
    bit            in_reset;

    // -------------------------------------------------------------------
    // predictor: updates the shadow and queues the results this access causes
    // -------------------------------------------------------------------
    function automatic int cache_predict(input logic [1:0] req, input logic [31:0] addr,
                                         input logic [31:0] data, input logic [31:0] mask);
        int            n;
        int            ln;
        int            base;
        int            wi;
        logic [5:0]    set_idx;
        logic [19:0]   tag_val;
        logic [15:0]   nxt;
        cache_result_t r;
        n = 0;
        set_idx = addr[OFFSET_BITS +: SET_BITS];
        tag_val = addr[31 -: 20];
        if (req == REQ_FILL)
        begin
            if (!miss_open)
                return 0;
            sh_words[miss_line * WORDS + fill_words] = data;
            fill_words++;
            if (fill_words < WORDS)
                return 0;
            fill_words = 0;
            miss_open = 0;
            sh_valid[miss_line] = 1;
            sh_dirty[miss_line] = 0;
            sh_tag[miss_line] = miss_addr[31 -: 20];
            wi = miss_line * WORDS + miss_addr[2 +: OFFSET_BITS - 2];
            if (miss_is_write)
            begin
                sh_words[wi] = (sh_words[wi] & ~miss_mask) | (miss_data & miss_mask);
                sh_dirty[miss_line] = 1;
                return 0;
            end
            r = '{KIND_READ_DATA, '0, '0, sh_words[wi], 1'b1};
            planned.push_back(r);
            return 1;
        end
        if (req == REQ_NONE || miss_open)
            return 0;
        base = int'(set_idx) << WAY_BITS;
        for (int w = 0; w < (1 << WAY_BITS); w++)
        begin
            ln = base + w;
            if (sh_valid[ln] && sh_tag[ln] == tag_val)
            begin
                wi = ln * WORDS + addr[2 +: OFFSET_BITS - 2];
                if (req == REQ_WRITE)
                begin
                    sh_words[wi] = (sh_words[wi] & ~mask) | (data & mask);
                    sh_dirty[ln] = 1;
                    return 0;
                end
                r = '{KIND_READ_DATA, '0, '0, sh_words[wi], 1'b1};
                planned.push_back(r);
                return 1;
            end
        end
        // miss: step the victim lfsr
        nxt = sh_lfsr >> 1;
        if (sh_lfsr[0])
            nxt = nxt ^ LFSR_TAPS;
        sh_lfsr = nxt;
        ln = base + int'(sh_lfsr[WAY_BITS-1:0]);
        if (sh_valid[ln] && sh_dirty[ln])
        begin
            for (int w = 0; w < WORDS; w++)
            begin
                r = '{KIND_WRITEBACK, {sh_tag[ln], set_idx}, w[3:0],
                      sh_words[ln * WORDS + w], 1'b0};
                planned.push_back(r);
                n++;
            end
        end
        sh_valid[ln] = 0;
        sh_dirty[ln] = 0;
        r = '{KIND_FILL_REQ, addr[31:OFFSET_BITS], '0, '0, 1'b1};
        planned.push_back(r);
        n++;
        miss_open = 1;
        miss_is_write = (req == REQ_WRITE);
        miss_addr = addr;
        miss_data = data;
        miss_mask = mask;
        miss_line = ln;
        fill_words = 0;
        return n;
    endfunction

    task automatic queue_access(input logic [1:0] req, input logic [31:0] addr,
                                input logic [31:0] data, input logic [31:0] mask,
                                input int phase, input bit drain);
        cache_access_t a;
        a.req = req;
        a.addr = addr;
        a.data = data;
        a.mask = mask;
        a.phase = phase;
        a.drain = drain;
        a.n_res = cache_predict(req, addr, data, mask);
        access_queue.push_back(a);
    endtask

    // percentage of cycles the sender sits idle in each phase
    function automatic int idle_pct(input int phase);
        case (phase)
            1:       return 47;
            3:       return 35;
            default: return 0;
        endcase
    endfunction

    // -------------------------------------------------------------------
    // clock, reset and stimulus generation
    // -------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        logic [19:0] tag_pool [8];
        logic [5:0]  set_pool [3];
        logic [31:0] a;
        int          nrand;
        int          phase;
        rst_n = 0;
        in_reset = 1;
        foreach (sh_valid[i])
        begin
            sh_valid[i] = 0;
            sh_dirty[i] = 0;
        end
        sh_lfsr = LFSR_SEED;
        miss_open = 0;
        fill_words = 0;

        // directed part: ignored requests, read miss, hits, masks, write miss
        queue_access(REQ_FILL, 32'h0, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 0, 0);
        queue_access(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        queue_access(REQ_READ, 32'h0, 32'h0, 32'h0, 0, 0);
        queue_access(REQ_WRITE, 32'h40, 32'h1234_5678, 32'hFFFF_FFFF, 0, 0); // ignored, miss open
        for (int w = 0; w < WORDS; w++)
            queue_access(REQ_FILL, 32'hFFFF_FFFF, (w == 0) ? 32'h0 :
                         (w == 1) ? 32'hFFFF_FFFF : $urandom, $urandom, 0, 0);
        queue_access(REQ_READ, 32'h7, 32'h0, 32'h0, 0, 0);
        queue_access(REQ_WRITE, 32'h4, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 0, 0);
        queue_access(REQ_WRITE, 32'h4, 32'hFFFF_FFFF, 32'h0, 0, 0);
        queue_access(REQ_WRITE, 32'h3C, 32'hFFFF_FFFF, 32'h0F0F_00FF, 0, 0);
        queue_access(REQ_READ, 32'h4, 32'h0, 32'h0, 0, 0);
        queue_access(REQ_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 0, 0);
        for (int w = 0; w < WORDS; w++)
            queue_access(REQ_FILL, 32'h0, $urandom, 32'h0, 0, 0);
        // the sender drains everything before this one
        queue_access(REQ_READ, 32'hFFFF_FFFC, 32'h0, 32'h0, 0, 1);

        // random part: a small pool of tags on a few sets forces dirty evictions
        foreach (tag_pool[i])
            tag_pool[i] = (i == 0) ? 20'h0 : (i == 1) ? 20'hFFFFF : 20'($urandom);
        set_pool[0] = 6'h00;
        set_pool[1] = 6'h3F;
        set_pool[2] = 6'($urandom);
        nrand = 0;
        while (nrand < 400)
        begin
            phase = nrand / 100;
            if (miss_open)
            begin
                // mostly fill beats, now and then a request that is ignored
                if ($urandom_range(19) == 0)
                    queue_access(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                 phase, 0);
                else
                    queue_access(REQ_FILL, $urandom, $urandom, $urandom, phase, 0);
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    a = $urandom;
                else
                    a = {tag_pool[$urandom_range(7)], set_pool[$urandom_range(2)],
                         6'($urandom)};
                case ($urandom_range(9))
                    0:       queue_access($urandom_range(1) ? REQ_FILL : REQ_NONE, a,
                                          $urandom, $urandom, phase, 0);
                    1, 2, 3, 4:
                             queue_access(REQ_READ, a, $urandom, $urandom, phase,
                                          nrand % 100 == 50);
                    default: queue_access(REQ_WRITE, a, $urandom,
                                          $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom,
                                          phase, nrand % 100 == 50);
                endcase
            end
            nrand++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1;
        in_reset <= 0;
        wait (access_queue.size() == 0 && awaited.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // -------------------------------------------------------------------
    // driver: offers the head of the access queue, one transaction per accept
    // -------------------------------------------------------------------
    initial
    begin
        start = 0;
        req_type = REQ_READ;
        address = '0;
        data_in = '0;
        write_mask = '0;
        hold_count = 0;
    end

    always @(posedge clk)
    begin
        bit offered;
        offered = start;
        if (!in_reset)
        begin
            if (start && !busy)
            begin
                // accepted: release the results this transaction causes
                for (int k = 0; k < access_queue[0].n_res; k++)
                    awaited.push_back(planned.pop_front());
                void'(access_queue.pop_front());
                offered = 0;
            end
            if (offered)
            begin
                // still waiting on busy, keep the same transaction on the ports
            end
            else if (access_queue.size() == 0)
                start <= 0;
            else if (access_queue[0].drain && (awaited.size() != 0 || hold_count < 40))
            begin
                // pause until the cache has delivered everything, then settle
                start <= 0;
                hold_count = (awaited.size() != 0) ? 0 : hold_count + 1;
            end
            else if ($urandom_range(99) < idle_pct(access_queue[0].phase))
                start <= 0;
            else
            begin
                start <= 1;
                req_type <= access_queue[0].req;
                address <= access_queue[0].addr;
                data_in <= access_queue[0].data;
                write_mask <= access_queue[0].mask;
                hold_count = 0;
            end
        end
    end

    // -------------------------------------------------------------------
    // monitor: every strobe is checked against the oldest awaited result
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n && strobe)
        begin
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d block %h beat %0d data %h last %0b",
                             result_kind, block_number, beat_index, data_out, last);
            end
            else
            begin
                e = awaited.pop_front();
                if (result_kind !== e.kind || block_number !== e.blk ||
                    beat_index !== e.beat || data_out !== e.word || last !== e.fin)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected kind %0d block %h beat %0d data %h last %0b, got kind %0d block %h beat %0d data %h last %0b",
                                 e.kind, e.blk, e.beat, e.word, e.fin, result_kind,
                                 block_number, beat_index, data_out, last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sawbc_pkg.sv
design/sawbc_data_ram.sv
design/set_assoc_write_back_cache.sv
design/sawbc_checker.sv
verif/set_assoc_write_back_cache_test.sv
